// ===== rtl/core/lrr_pkg.sv =====
package lrr_pkg;

    localparam logic [7:0] NEWLINE = 8'h0A;

    typedef enum logic [1:0] {
        CMD_RX    = 2'd0,
        CMD_TAKE  = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NOP   = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RX,
        ST_TAKE,
        ST_RDY_RD,
        ST_RDY,
        ST_BYTE_RD,
        ST_BYTE_OUT,
        ST_RESULT
    } t_state;

    typedef struct packed {
        logic rd;
        logic we;
        logic clr_one;
        logic clr_all;
    } t_meta_ctl;

endpackage

// ===== rtl/core/lrr_line_mem.sv =====
module lrr_line_mem #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/lrr_meta_mem.sv =====
module lrr_meta_mem #(
    parameter int NUM_LINES = 4,
    parameter int SLOT_W    = 2,
    parameter int LEN_W     = 7
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lrr_pkg::t_meta_ctl i_ctl,
    input  logic [SLOT_W-1:0] i_rd_slot,
    input  logic [SLOT_W-1:0] i_wr_slot,
    input  logic [LEN_W-1:0]  i_wr_len,
    input  logic              i_wr_nl,
    input  logic [SLOT_W-1:0] i_clr_slot,
    output logic [LEN_W-1:0]  o_len,
    output logic              o_nl
);

    logic [LEN_W:0]     mem [NUM_LINES];
    logic [NUM_LINES-1:0] r_valid;
    logic [LEN_W:0]     r_rd_data;
    logic               r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            mem[i_wr_slot] <= {i_wr_len, i_wr_nl};
        end
        if (i_ctl.rd) begin
            r_rd_data <= mem[i_rd_slot];
        end
    end

    // an entry without its valid bit reads as empty
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_ctl.clr_all) begin
                r_valid <= '0;
            end else begin
                if (i_ctl.we) begin
                    r_valid[i_wr_slot] <= 1'b1;
                end
                if (i_ctl.clr_one) begin
                    r_valid[i_clr_slot] <= 1'b0;
                end
            end
            if (i_ctl.rd) begin
                r_rd_valid <= r_valid[i_rd_slot];
            end
        end
    end

    assign o_len = r_rd_valid ? r_rd_data[LEN_W:1] : '0;
    assign o_nl  = r_rd_valid & r_rd_data[0];

endmodule

// ===== rtl/core/line_assembling_receive_ring.sv =====
// Receive and clear: result registered in RESULT, reached through RX (receive only), RDY_RD and RDY after accept.
// Take: passes TAKE, RDY_RD and RDY, then alternates BYTE_RD and BYTE_OUT for each byte, paced by the
// single registered read port of the line memory; an empty take answers from RESULT.
// One request at a time; the next is taken the cycle after the last result is loaded.
// Synchronous active-low reset: pointers zero, all slots empty, output register empty.
module line_assembling_receive_ring #(
    parameter int LINE_LEN  = 64,
    parameter int NUM_LINES = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_cmd,
    input  logic [7:0] i_rx_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_byte,
    output logic       o_out_valid,
    output logic       o_out_last,
    output logic       o_line_ready
);

    localparam int DEPTH  = NUM_LINES * LINE_LEN;
    localparam int AW     = $clog2(DEPTH);
    localparam int SLOT_W = $clog2(NUM_LINES);
    localparam int LEN_W  = $clog2(LINE_LEN + 1);
    localparam int POS_W  = $clog2(LINE_LEN);

    function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
        next_slot = (s == SLOT_W'(NUM_LINES - 1)) ? '0 : s + SLOT_W'(1);
    endfunction

    lrr_pkg::t_state r_state, n_state;
    lrr_pkg::t_cmd   r_cmd;
    logic [7:0]        r_byte;
    logic [SLOT_W-1:0] r_wslot, r_rslot;
    logic [LEN_W-1:0]  r_cnt;
    logic [POS_W-1:0]  r_idx;
    logic [AW-1:0]     r_base;
    logic              r_rdy;
    logic              r_o_valid;
    logic [7:0]        r_o_byte;
    logic              r_o_out_valid, r_o_last, r_o_ready;

    lrr_pkg::t_meta_ctl meta_ctl;
    logic [SLOT_W-1:0] meta_rd_slot, meta_clr_slot;
    logic [LEN_W-1:0]  meta_wr_len, meta_len;
    logic              meta_wr_nl, meta_nl;

    logic              line_we, line_re;
    logic [AW-1:0]     line_waddr, line_raddr;
    logic [7:0]        line_rdata;

    logic              accept, out_free, out_load, byte_last;
    logic [LEN_W-1:0]  rx_n0, rx_n1;
    logic              rx_close;

    assign accept    = i_valid && (r_state == lrr_pkg::ST_IDLE);
    assign out_free  = !r_o_valid || !i_stall;
    assign byte_last = (LEN_W'(r_idx) + LEN_W'(1)) == r_cnt;

    assign rx_n0    = (meta_len >= LEN_W'(LINE_LEN)) ? '0 : meta_len;
    assign rx_n1    = rx_n0 + LEN_W'(1);
    assign rx_close = (r_byte == lrr_pkg::NEWLINE) && (rx_n1 > LEN_W'(1));

    lrr_meta_mem #(
        .NUM_LINES (NUM_LINES),
        .SLOT_W    (SLOT_W),
        .LEN_W     (LEN_W)
    ) u_meta (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (meta_ctl),
        .i_rd_slot  (meta_rd_slot),
        .i_wr_slot  (r_wslot),
        .i_wr_len   (meta_wr_len),
        .i_wr_nl    (meta_wr_nl),
        .i_clr_slot (meta_clr_slot),
        .o_len      (meta_len),
        .o_nl       (meta_nl)
    );

    lrr_line_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (line_we),
        .i_waddr (line_waddr),
        .i_wdata (r_byte),
        .i_re    (line_re),
        .i_raddr (line_raddr),
        .o_rdata (line_rdata)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lrr_pkg::ST_IDLE: begin
                if (accept) begin
                    unique case (lrr_pkg::t_cmd'(i_cmd))
                        lrr_pkg::CMD_RX:    n_state = lrr_pkg::ST_RX;
                        lrr_pkg::CMD_TAKE:  n_state = lrr_pkg::ST_TAKE;
                        lrr_pkg::CMD_CLEAR: n_state = lrr_pkg::ST_RDY_RD;
                        lrr_pkg::CMD_NOP:   n_state = lrr_pkg::ST_RDY_RD;
                    endcase
                end
            end
            lrr_pkg::ST_RX:     n_state = lrr_pkg::ST_RDY_RD;
            lrr_pkg::ST_TAKE:   n_state = lrr_pkg::ST_RDY_RD;
            lrr_pkg::ST_RDY_RD: n_state = lrr_pkg::ST_RDY;
            lrr_pkg::ST_RDY: begin
                if (r_cmd == lrr_pkg::CMD_TAKE && r_cnt != '0) begin
                    n_state = lrr_pkg::ST_BYTE_RD;
                end else begin
                    n_state = lrr_pkg::ST_RESULT;
                end
            end
            lrr_pkg::ST_BYTE_RD: n_state = lrr_pkg::ST_BYTE_OUT;
            lrr_pkg::ST_BYTE_OUT: begin
                if (out_free) begin
                    n_state = byte_last ? lrr_pkg::ST_IDLE : lrr_pkg::ST_BYTE_RD;
                end
            end
            lrr_pkg::ST_RESULT: begin
                if (out_free) begin
                    n_state = lrr_pkg::ST_IDLE;
                end
            end
            default: n_state = lrr_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        meta_ctl      = '0;
        meta_rd_slot  = r_rslot;
        meta_clr_slot = r_rslot;
        meta_wr_len   = '0;
        meta_wr_nl    = 1'b0;
        line_we       = 1'b0;
        line_re       = 1'b0;
        line_waddr    = AW'(r_wslot) * AW'(LINE_LEN) + AW'(rx_n0[POS_W-1:0]);
        line_raddr    = r_base + AW'(r_idx);
        out_load      = 1'b0;
        unique case (r_state)
            lrr_pkg::ST_IDLE: begin
                if (accept) begin
                    meta_ctl.rd     = 1'b1;
                    meta_rd_slot    = (lrr_pkg::t_cmd'(i_cmd) == lrr_pkg::CMD_TAKE) ?
                                      r_rslot : r_wslot;
                    meta_ctl.clr_all = (lrr_pkg::t_cmd'(i_cmd) == lrr_pkg::CMD_CLEAR);
                end
            end
            lrr_pkg::ST_RX: begin
                meta_ctl.we = 1'b1;
                line_we     = 1'b1;
                meta_wr_nl  = (r_byte == lrr_pkg::NEWLINE);
                if (rx_close) begin
                    meta_wr_len      = rx_n1;
                    meta_ctl.clr_one = 1'b1;
                    meta_clr_slot    = next_slot(r_wslot);
                end else begin
                    meta_wr_len = (rx_n1 >= LEN_W'(LINE_LEN)) ? '0 : rx_n1;
                end
            end
            lrr_pkg::ST_TAKE: begin
                meta_ctl.clr_one = 1'b1;
            end
            lrr_pkg::ST_RDY_RD: begin
                meta_ctl.rd = 1'b1;
            end
            lrr_pkg::ST_RDY: begin
            end
            lrr_pkg::ST_BYTE_RD: begin
                line_re = 1'b1;
            end
            lrr_pkg::ST_BYTE_OUT: begin
                out_load = out_free;
            end
            lrr_pkg::ST_RESULT: begin
                out_load = out_free;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= lrr_pkg::ST_IDLE;
            r_wslot   <= '0;
            r_rslot   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == lrr_pkg::ST_RX && rx_close) begin
                r_wslot <= next_slot(r_wslot);
            end
            if (r_state == lrr_pkg::ST_TAKE) begin
                r_rslot <= next_slot(r_rslot);
            end
            if (out_load) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd  <= lrr_pkg::t_cmd'(i_cmd);
            r_byte <= i_rx_byte;
        end
        if (r_state == lrr_pkg::ST_TAKE) begin
            r_cnt  <= meta_len;
            r_base <= AW'(r_rslot) * AW'(LINE_LEN);
            r_idx  <= '0;
        end
        if (r_state == lrr_pkg::ST_RDY) begin
            r_rdy <= (meta_len != '0) && meta_nl;
        end
        if (r_state == lrr_pkg::ST_BYTE_OUT && out_free) begin
            r_idx <= r_idx + POS_W'(1);
        end
        if (out_load) begin
            r_o_ready <= r_rdy;
            if (r_state == lrr_pkg::ST_BYTE_OUT) begin
                r_o_byte      <= line_rdata;
                r_o_out_valid <= 1'b1;
                r_o_last      <= byte_last;
            end else begin
                r_o_byte      <= '0;
                r_o_out_valid <= 1'b0;
                r_o_last      <= 1'b1;
            end
        end
    end

    assign o_stall      = (r_state != lrr_pkg::ST_IDLE);
    assign o_valid      = r_o_valid;
    assign o_out_byte   = r_o_byte;
    assign o_out_valid  = r_o_out_valid;
    assign o_out_last   = r_o_last;
    assign o_line_ready = r_o_ready;

`ifndef SYNTHESIS
    a_meta_no_rw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(meta_ctl.rd && meta_ctl.we))
        else $error("slot metadata read and written in one cycle");

    a_take_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lrr_pkg::ST_TAKE) |=> (r_rslot != $past(r_rslot)))
        else $error("read pointer did not advance on take");

    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_out_valid) |-> (o_out_last && o_out_byte == 8'h00))
        else $error("non-byte result not marked last or not zero");
`endif

endmodule
